FILE: src/bffa_pkg.sv
// bffa_pkg: shared constants, operation codes and controller/datapath link types
// for the bitmap first-free allocator; no dependencies
`default_nettype none

package bffa_pkg;

  localparam int NUM_BITS_DEFAULT = 256;

  localparam int BYTE_W     = 8;
  localparam int SCAN_LANES = 8;
  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 8;
  localparam int ACTIVE_W   = 6;

  localparam logic [ACTIVE_W-1:0] ACTIVE_BYTES_RESET = 6'd32;
  localparam logic [BYTE_W-1:0]   FULL_BYTE          = 8'hFF;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  typedef struct packed {
    logic load;
    logic simple_commit;
    logic scan_advance;
    logic scan_commit;
  } cmd_t;

  typedef struct packed {
    logic kind_is_alloc;
    logic scan_hit;
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/bffa_if.sv
// bffa_if: request and response channel interfaces (valid/ready plus payload)
// depends on bffa_pkg for field widths
`default_nettype none

interface bffa_req_if;
  logic                               valid;
  logic                               ready;
  logic [bffa_pkg::KIND_W-1:0]        kind;
  logic [bffa_pkg::INDEX_W-1:0]       bit_index;
  logic                               bit_value;

  modport source (output valid, output kind, output bit_index, output bit_value, input ready);
  modport sink   (input valid, input kind, input bit_index, input bit_value, output ready);
endinterface

interface bffa_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               read_value;
  logic                               found;
  logic [bffa_pkg::INDEX_W-1:0]       found_index;
  logic                               range_error;

  modport source (output valid, output read_value, output found, output found_index,
                  output range_error, input ready);
  modport sink   (input valid, input read_value, input found, input found_index,
                  input range_error, output ready);
endinterface

`default_nettype wire

FILE: src/bitmap_first_free_allocator.sv
// bitmap_first_free_allocator: top level, joins controller and datapath
// depends on bffa_pkg, bffa_if, bffa_ctrl, bffa_dpath
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    kind, bit_index, bit_value
//   rsp      out  valid/ready    read_value, found, found_index, range_error
//   cfg      in   cfg_write_en   cfg_write_data (active_bytes)
//
// write, read and clear-all are latched on accept, then commit once the output slot is free
// allocate scans groups of 8 bytes (up to 4 at 32 bytes) from the lowest up
// with the one-group-per-cycle zero-bit scanner, committing once the output slot is free
// one item in flight; a new request is taken while the previous beat waits on rsp
// a full output register holds the finished item until rsp drains
// synchronous reset clears the store and sets active_bytes to 32, no clearing pass
`default_nettype none

module bitmap_first_free_allocator #(
  parameter int NUM_BITS = bffa_pkg::NUM_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  bffa_req_if.sink                           req,
  bffa_rsp_if.source                         rsp,
  input  wire logic                          cfg_write_en,
  input  wire logic [bffa_pkg::ACTIVE_W-1:0] cfg_write_data
);

  bffa_pkg::cmd_t cmd;
  bffa_pkg::sts_t sts;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bffa_dpath #(
    .NUM_BITS (NUM_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_kind       (req.kind),
    .req_bit_index  (req.bit_index),
    .req_bit_value  (req.bit_value),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .sts            (sts),
    .read_value     (rsp.read_value),
    .found          (rsp.found),
    .found_index    (rsp.found_index),
    .range_error    (rsp.range_error)
  );

endmodule

`default_nettype wire

FILE: src/bffa_ctrl.sv
// bffa_ctrl: controller state machine, sequences accept, scan and result commit
// depends on bffa_pkg (cmd_t, sts_t)
`default_nettype none

module bffa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  input  wire bffa_pkg::sts_t sts,
  output bffa_pkg::cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;
  logic out_free;

  // output slot is free if empty or draining this cycle
  assign out_free  = !out_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!sts.kind_is_alloc) begin
          if (out_free) begin
            cmd.simple_commit = 1'b1;
            state_next        = ST_IDLE;
          end
        end else if (sts.scan_hit || sts.scan_last) begin
          if (out_free) begin
            cmd.scan_commit = 1'b1;
            state_next      = ST_IDLE;
          end
        end else begin
          cmd.scan_advance = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.simple_commit || cmd.scan_commit) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // a result never overwrites one that is still waiting
  a_commit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.simple_commit || cmd.scan_commit) |-> (!out_valid || rsp_ready))
    else $error("result committed over a pending beat");

  // no commit while the request side is open
  a_idle_no_commit: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !(cmd.simple_commit || cmd.scan_commit || cmd.scan_advance))
    else $error("datapath command while idle");

  // the scan never walks past the last active group
  a_no_advance_at_end: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_advance |-> (!sts.scan_last && !sts.scan_hit))
    else $error("scan advanced past hit or last group");

  // a commit always leaves a beat on the output
  a_commit_shows_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd.simple_commit || cmd.scan_commit) |=> out_valid)
    else $error("commit without output beat");

endmodule

`default_nettype wire

FILE: src/bffa_dpath.sv
// bffa_dpath: bit store, active-size register, request latch, group scanner
// and result register; depends on bffa_pkg
`default_nettype none

module bffa_dpath #(
  parameter int NUM_BITS = bffa_pkg::NUM_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bffa_pkg::cmd_t                    cmd,
  input  wire logic [bffa_pkg::KIND_W-1:0]       req_kind,
  input  wire logic [bffa_pkg::INDEX_W-1:0]      req_bit_index,
  input  wire logic                              req_bit_value,
  input  wire logic                              cfg_write_en,
  input  wire logic [bffa_pkg::ACTIVE_W-1:0]     cfg_write_data,
  output bffa_pkg::sts_t                         sts,
  output logic                                   read_value,
  output logic                                   found,
  output logic [bffa_pkg::INDEX_W-1:0]           found_index,
  output logic                                   range_error
);

  localparam int BYTE_W      = bffa_pkg::BYTE_W;
  localparam int LANES       = bffa_pkg::SCAN_LANES;
  localparam int STORE_BYTES = (NUM_BITS + BYTE_W - 1) / BYTE_W;
  localparam int STORE_W     = STORE_BYTES * BYTE_W;
  localparam int ACTIVE_MAX  = (1 << bffa_pkg::ACTIVE_W) - 1;
  localparam int STORE_CAP   = (STORE_BYTES > ACTIVE_MAX) ? ACTIVE_MAX : STORE_BYTES;
  localparam int GROUPS      = (STORE_CAP + LANES - 1) / LANES;
  localparam int GW          = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int GROUP_W     = LANES * BYTE_W;
  localparam int OFF_W       = $clog2(GROUP_W);
  localparam int LW          = $clog2(LANES);
  localparam int SCAN_W      = (2 ** GW) * GROUP_W;
  localparam int PW          = $clog2(STORE_W);
  localparam int AW          = bffa_pkg::ACTIVE_W;

  logic [STORE_W-1:0]               bit_store;
  logic [STORE_W-1:0]               cleared;
  logic [AW-1:0]                    active_bytes;
  logic [AW-1:0]                    used_bytes;
  logic [bffa_pkg::KIND_W-1:0]      kind_q;
  logic [bffa_pkg::INDEX_W-1:0]     index_q;
  logic                             value_q;
  logic [GW-1:0]                    grp;
  logic                             in_range;
  logic [PW-1:0]                    pos;
  logic [SCAN_W-1:0]                scan_vec;
  logic [GROUP_W-1:0]               group_word;
  logic [GROUP_W-1:0]               lane_word;
  logic                             hit;
  logic [OFF_W-1:0]                 off;
  logic [GW+OFF_W-1:0]              alloc_abs;
  logic [PW-1:0]                    alloc_pos;

  assign used_bytes = (active_bytes > AW'(STORE_CAP)) ? AW'(STORE_CAP) : active_bytes;
  assign in_range   = (AW+1)'(index_q[bffa_pkg::INDEX_W-1:LW]) < (AW+1)'(used_bytes);
  assign pos        = PW'(index_q);

  // bytes beyond the store read as full so the scanner skips them
  generate
    if (SCAN_W > STORE_W) begin : g_pad
      assign scan_vec = {{(SCAN_W - STORE_W){1'b1}}, bit_store};
    end else begin : g_trim
      assign scan_vec = bit_store[SCAN_W-1:0];
    end
  endgenerate

  assign group_word = scan_vec[grp * GROUP_W +: GROUP_W];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      if (7'({grp, LW'(j)}) < {1'b0, used_bytes}) begin
        lane_word[j*BYTE_W +: BYTE_W] = group_word[j*BYTE_W +: BYTE_W];
      end else begin
        lane_word[j*BYTE_W +: BYTE_W] = bffa_pkg::FULL_BYTE;
      end
    end
  end

  // lowest zero bit of the current group
  always_comb begin
    hit = 1'b0;
    off = '0;
    for (int k = GROUP_W - 1; k >= 0; k--) begin
      if (!lane_word[k]) begin
        hit = 1'b1;
        off = OFF_W'(k);
      end
    end
  end

  assign alloc_abs = {grp, off};
  assign alloc_pos = PW'(alloc_abs);

  always_comb begin
    cleared = bit_store;
    for (int b = 0; b < STORE_BYTES; b++) begin
      if ((b < STORE_CAP) && (AW'(b) < used_bytes)) begin
        cleared[b*BYTE_W +: BYTE_W] = '0;
      end
    end
  end

  assign sts.kind_is_alloc = (kind_q == bffa_pkg::KIND_ALLOC);
  assign sts.scan_hit      = hit;
  assign sts.scan_last     = (7'({grp, LW'(0)}) + 7'(LANES)) >= {1'b0, used_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bytes <= bffa_pkg::ACTIVE_BYTES_RESET;
    end else if (cfg_write_en) begin
      active_bytes <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= req_kind;
      index_q <= req_bit_index;
      value_q <= req_bit_value;
      grp     <= '0;
    end else if (cmd.scan_advance) begin
      grp <= grp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store <= '0;
    end else if (cmd.simple_commit) begin
      case (kind_q)
        bffa_pkg::KIND_WRITE: begin
          if (in_range) begin
            bit_store[pos] <= value_q;
          end
        end
        bffa_pkg::KIND_CLEAR: begin
          bit_store <= cleared;
        end
        default: begin
        end
      endcase
    end else if (cmd.scan_commit && hit) begin
      bit_store[alloc_pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.simple_commit) begin
      read_value  <= (kind_q == bffa_pkg::KIND_READ) && in_range && bit_store[pos];
      found       <= 1'b0;
      found_index <= '0;
      range_error <= ((kind_q == bffa_pkg::KIND_WRITE) || (kind_q == bffa_pkg::KIND_READ))
                     && !in_range;
    end else if (cmd.scan_commit) begin
      read_value  <= 1'b0;
      found       <= hit;
      found_index <= hit ? bffa_pkg::INDEX_W'(alloc_abs) : '0;
      range_error <= 1'b0;
    end
  end

endmodule

`default_nettype wire
